FILE: hdl/lrc_pkg.sv
package lrc_pkg;

  localparam int MAX_PARTS    = 32;
  localparam int COUNT_W      = 6;
  localparam int MAX_ERASURES = 4;
  localparam int SMALL_LIMIT  = 3;
  localparam int MASK_W       = 16;

  typedef logic [MASK_W-1:0] mask_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef struct packed {
    logic  can_repair;
    mask_t repair_mask;
  } plan_t;

  function automatic count_t popcount(input logic [MAX_PARTS-1:0] v);
    count_t c;
    c = '0;
    for (int i = 0; i < MAX_PARTS; i++) begin
      c = c + count_t'(v[i]);
    end
    return c;
  endfunction

endpackage

FILE: hdl/lrc_repair_set_planner.sv
// Repair-set planner for a locally repairable code with DATA_PARTS data
// parts, two local xor parities and two global parities.
// Input channel: in_valid, in_stall, erased_mask (bit i set when part i is
// erased; data parts first, then xor parities, then global parities).
// Output channel: out_valid, out_stall, can_repair, repair_mask (parts to
// read, zero when the erased set cannot be rebuilt).
// An accepted item passes through the input register and then the result
// register, which presents it on the output. Throughput is one item per
// cycle while the output does not stall; the whole decision (a population
// count over the mask and a few compares) sits between the two registers.
// When the receiver raises out_stall the result register holds; the input
// register still takes an item while the result register is full, and
// in_stall rises only when both registers hold items and the output stalls.
// Reset (synchronous, active high) empties both registers; no item is lost
// or produced by reset beyond dropping items not yet delivered.
module lrc_repair_set_planner #(
  parameter int DATA_PARTS = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lrc_pkg::mask_t       erased_mask,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 can_repair,
  output lrc_pkg::mask_t       repair_mask
);
  import lrc_pkg::*;

  localparam int TOTAL_PARTS = DATA_PARTS + 4;
  localparam int HALF        = DATA_PARTS / 2;

  localparam logic [TOTAL_PARTS-1:0] ALL_MASK  = '1;
  localparam logic [TOTAL_PARTS-1:0] DATA_MASK =
    TOTAL_PARTS'((64'd1 << DATA_PARTS) - 64'd1);
  localparam logic [TOTAL_PARTS-1:0] HALF_MASK =
    TOTAL_PARTS'((64'd1 << HALF) - 64'd1);
  localparam logic [TOTAL_PARTS-1:0] XOR0_BIT  = TOTAL_PARTS'(64'd1 << DATA_PARTS);
  localparam logic [TOTAL_PARTS-1:0] XOR1_BIT  =
    TOTAL_PARTS'(64'd1 << (DATA_PARTS + 1));
  localparam logic [TOTAL_PARTS-1:0] GRP0_MASK = HALF_MASK | XOR0_BIT;
  localparam logic [TOTAL_PARTS-1:0] GRP1_MASK = (DATA_MASK & ~HALF_MASK) | XOR1_BIT;

  logic                   valid1;
  mask_t                  mask1;
  logic                   out_load;
  logic                   in_load;
  logic [TOTAL_PARTS-1:0] erased;
  count_t                 n;
  count_t                 cov0;
  count_t                 cov1;
  logic [TOTAL_PARTS-1:0] reads;
  plan_t                  plan_next;
  plan_t                  plan;

  assign out_load = valid1 && (!out_valid || !out_stall);
  assign in_stall = valid1 && !out_load;
  assign in_load  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else if (in_load) begin
      valid1 <= 1'b1;
    end else if (out_load) begin
      valid1 <= 1'b0;
    end
    if (in_load) begin
      mask1 <= erased_mask;
    end
  end

  always_comb begin
    erased = TOTAL_PARTS'(mask1) & ALL_MASK;
    n      = popcount(MAX_PARTS'(erased));
    cov0   = popcount(MAX_PARTS'(erased & GRP0_MASK));
    cov1   = popcount(MAX_PARTS'(erased & GRP1_MASK));
    reads  = '0;
    plan_next.can_repair = 1'b0;
    priority if (n == '0) begin
      plan_next.can_repair = 1'b1;
    end else if (n > count_t'(MAX_ERASURES)) begin
      plan_next.can_repair = 1'b0;
    end else if (n == count_t'(1) && cov0 != '0) begin
      plan_next.can_repair = 1'b1;
      reads = GRP0_MASK & ~erased;
    end else if (n == count_t'(1) && cov1 != '0) begin
      plan_next.can_repair = 1'b1;
      reads = GRP1_MASK & ~erased;
    end else if (n == count_t'(MAX_ERASURES) && (cov0 == '0 || cov1 == '0)) begin
      plan_next.can_repair = 1'b0;
    end else if (n == count_t'(2) && cov0 == count_t'(1) && cov1 == count_t'(1)) begin
      plan_next.can_repair = 1'b1;
      reads = (GRP0_MASK | GRP1_MASK) & ~erased;
    end else if ((erased & DATA_MASK) == '0) begin
      plan_next.can_repair = 1'b1;
      reads = DATA_MASK;
    end else begin
      plan_next.can_repair = 1'b1;
      reads = ALL_MASK & ~erased;
      if (cov0 == '0 && n <= count_t'(SMALL_LIMIT)) begin
        reads = reads & ~XOR0_BIT;
      end
      if (cov1 == '0 && n <= count_t'(SMALL_LIMIT)) begin
        reads = reads & ~XOR1_BIT;
      end
    end
    plan_next.repair_mask = MASK_W'(reads);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      plan <= plan_next;
    end
  end

  assign can_repair  = plan.can_repair;
  assign repair_mask = plan.repair_mask;

  a_refused_reads_none : assert property (@(posedge clk) disable iff (rst)
    out_valid && !can_repair |-> repair_mask == '0)
    else $error("refused item carries a read mask");

  a_too_many_refused : assert property (@(posedge clk) disable iff (rst)
    valid1 && n > count_t'(MAX_ERASURES) |-> !plan_next.can_repair)
    else $error("more erasures than the code tolerates marked repairable");

  a_stage_advances : assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid)
    else $error("result register did not take the item");

  a_input_taken : assert property (@(posedge clk) disable iff (rst)
    in_load |=> valid1)
    else $error("input register did not take the item");

  a_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> !out_load)
    else $error("stalled result overwritten");

endmodule
